[rtl/ntt_pkg.sv]
// Shared types and constants for the forward NTT unit.
// No dependencies.
package ntt_pkg;
  localparam int LOG_N_MAX = 10;
  localparam logic [1:0] FUNC_WR_COEF = 2'd0;
  localparam logic [1:0] FUNC_WR_TWID = 2'd1;
  localparam logic [1:0] FUNC_RUN     = 2'd2;
  localparam logic [1:0] FUNC_RD_COEF = 2'd3;
  localparam logic [1:0] CFG_MODULUS  = 2'd0;
  localparam logic [1:0] CFG_MOD_INV  = 2'd1;
  localparam logic [1:0] CFG_SIZE_LOG = 2'd2;
  localparam int WORD_W = 64;
  localparam int MOD_W = 62;
  typedef logic [WORD_W-1:0] word_t;
endpackage

[rtl/ntt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ntt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[rtl/ntt_mul64.sv]
// 64x64 to 128 multiplier split into four 32x32 partial products, registered and then summed.
// Depends on ntt_pkg.
module ntt_mul64
  import ntt_pkg::*;
(
  input  logic         clk,
  input  word_t        a,
  input  word_t        b,
  output logic [127:0] p
);
  logic [63:0] p0_r, p1_r, p2_r, p3_r;
  always_ff @(posedge clk) begin
    p0_r <= 64'(a[31:0]) * 64'(b[31:0]);
    p1_r <= 64'(a[31:0]) * 64'(b[63:32]);
    p2_r <= 64'(a[63:32]) * 64'(b[31:0]);
    p3_r <= 64'(a[63:32]) * 64'(b[63:32]);
  end
  assign p = {p3_r, p0_r} + {32'd0, p1_r, 32'd0} + {32'd0, p2_r, 32'd0};
endmodule

[rtl/ntt_forward_montgomery_unit.sv]
// Top level of the forward NTT unit with Montgomery butterflies.
// Depends on ntt_pkg, ntt_ram and ntt_mul64.
//
// Channel | dir | fields
// in_     | in  | tdata = {value, index}, tuser = func
// out_    | out | tdata = data, tuser = done_res
// cfg_    | in  | cfg_index, cfg_data
//
// A run item does N/2*log2(N) butterflies and then a done item; each butterfly
// reads x and y from the coefficient memory, multiplies y by the twiddle, reduces
// by Montgomery and writes y and then x back. Write items are taken back to back;
// a read item has its result registered via the RAM read and the S_RD state.
// Reset is synchronous and needs no memory clearing. A waiting result stalls only new work.
module ntt_forward_montgomery_unit
  import ntt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // index[9:0] (width LOG_N_MAX), value[73:10]
  input  logic [1:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // data
  output logic        out_tuser,  // done_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  localparam int AW = LOG_N_MAX;
  localparam int DEPTH = 1 << LOG_N_MAX;

  localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_RX = 4'd3,
    S_RY = 4'd4, S_M1 = 4'd5, S_M2 = 4'd6, S_M3 = 4'd7, S_M4 = 4'd8,
    S_WY = 4'd9, S_WX = 4'd10, S_NEXT = 4'd11;

  logic [3:0] st_r;
  logic [MOD_W-1:0] q_r;
  word_t qinv_r;
  logic [3:0] slog_r;
  logic [AW:0] m_r, t_r, i_r, j_r;
  word_t x_r, v_r, u1_r, w_r;
  logic out_v_r, out_u_r;
  word_t out_d_r;

  logic c_we, t_we;
  logic [AW-1:0] c_wa, c_ra, t_ra;
  word_t c_wd, c_rd, t_rd;
  word_t ma, mb;
  logic [127:0] mp;

  logic [AW-1:0] in_idx;
  logic [AW:0] px, py;
  word_t q64, s_sum;

  assign in_idx = in_tdata[AW-1:0];
  assign q64 = {2'b00, q_r};
  assign px = ((i_r * t_r) << 1) + j_r;
  assign py = px + t_r;
  assign s_sum = x_r + v_r;

  ntt_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_coef (.clk(clk), .we(c_we), .waddr(c_wa),
    .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));
  ntt_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_twid (.clk(clk), .we(t_we), .waddr(in_idx),
    .wdata(in_tdata[AW+63:AW]), .raddr(t_ra), .rdata(t_rd));
  ntt_mul64 u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  assign in_tready = (st_r == S_IDLE) && !out_v_r;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_v_r;
  assign out_tdata = out_d_r;
  assign out_tuser = out_u_r;

  always_comb begin
    c_we = 1'b0;
    c_wa = in_idx;
    c_wd = in_tdata[AW+63:AW];
    c_ra = in_idx;
    t_we = 1'b0;
    t_ra = AW'(m_r + i_r);
    ma = c_rd;
    mb = w_r;
    if (st_r == S_IDLE && in_tvalid && in_tready) begin
      c_we = (in_tuser == FUNC_WR_COEF);
      t_we = (in_tuser == FUNC_WR_TWID);
    end
    if (st_r == S_RX || st_r == S_NEXT) c_ra = AW'(px);
    if (st_r == S_RY) c_ra = AW'(py);
    if (st_r == S_M2) begin
      ma = mp[63:0];
      mb = qinv_r;
    end
    if (st_r == S_M3) begin
      ma = mp[63:0];
      mb = q64;
    end
    if (st_r == S_WY) begin
      c_we = 1'b1;
      c_wa = AW'(py);
      c_wd = (x_r < v_r) ? x_r + q64 - v_r : x_r - v_r;
    end
    if (st_r == S_WX) begin
      c_we = 1'b1;
      c_wa = AW'(px);
      c_wd = (s_sum > q64) ? s_sum - q64 : s_sum;
    end
  end

  // S_M1: c_rd=y, mult y*w. S_M2: product ready, mult U0*qinv.
  // S_M3: Q ready, mult Q*q. S_M4: high half H ready, V formed.
  word_t h;
  assign h = mp[127:64];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      q_r <= MOD_W'(3);
      qinv_r <= 64'hAAAAAAAAAAAAAAAB;
      slog_r <= 4'd10;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MODULUS:  q_r <= cfg_data[MOD_W-1:0];
          CFG_MOD_INV:  qinv_r <= cfg_data;
          CFG_SIZE_LOG: slog_r <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (out_v_r && out_tready) out_v_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            if (in_tuser == FUNC_RD_COEF) st_r <= S_RD;
            if (in_tuser == FUNC_RUN) begin
              m_r <= (AW+1)'(1);
              i_r <= '0;
              j_r <= '0;
              t_r <= (AW+1)'(((AW+1)'(1) << ((slog_r > 4'(LOG_N_MAX)) ? LOG_N_MAX
                     : int'(slog_r))) >> 1);
              st_r <= (slog_r == 4'd0) ? S_NEXT : S_RX;
            end
          end
        end
        S_RD: begin
          out_v_r <= 1'b1;
          out_d_r <= c_rd;
          out_u_r <= 1'b0;
          st_r <= S_IDLE;
        end
        S_RX: st_r <= S_RY;
        S_RY: begin
          x_r <= c_rd;
          w_r <= t_rd;
          st_r <= S_M1;
        end
        S_M1: st_r <= S_M2;
        S_M2: begin
          u1_r <= mp[127:64];
          st_r <= S_M3;
        end
        S_M3: st_r <= S_M4;
        S_M4: begin
          v_r <= (u1_r < h) ? u1_r + q64 - h : u1_r - h;
          st_r <= S_WY;
        end
        S_NEXT: begin
          out_v_r <= 1'b1;
          out_d_r <= '0;
          out_u_r <= 1'b1;
          st_r <= S_IDLE;
        end
        S_WY: st_r <= S_WX;
        S_WX: begin
          st_r <= S_RX;
          if (j_r + 1'b1 < t_r) j_r <= j_r + 1'b1;
          else begin
            j_r <= '0;
            if (i_r + 1'b1 < m_r) i_r <= i_r + 1'b1;
            else begin
              i_r <= '0;
              if (t_r == (AW+1)'(1)) begin
                st_r <= S_NEXT;
              end else begin
                m_r <= m_r << 1;
                t_r <= t_r >> 1;
              end
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

[verif/tb_top.sv]
// Self-checking testbench for the forward NTT unit with Montgomery butterflies.
// Predicts each read and done item with a local transform model and compares them.
// Depends on ntt_pkg and the ntt_forward_montgomery_unit RTL.
module tb_top
  import ntt_pkg::*;
;

  localparam int DEPTH = 1024;
  localparam longint unsigned CYCLE_LIMIT = 64'd3000000;
  localparam logic [1:0] CFG_UNMAPPED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  typedef struct packed {
    logic [63:0] data;
    logic        done_res;
  } result_t;

  word_t       coef_mem [DEPTH];
  word_t       twid_mem [DEPTH];
  bit          coef_written [DEPTH];
  logic [61:0] mod_q;
  word_t       mod_qinv;
  logic [3:0]  size_lg;
  result_t     pending_results [$];
  int          error_count = 0;
  longint unsigned cycle_count = 0;
  bit          hold_off = 1'b0;

  ntt_forward_montgomery_unit u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  function automatic void montgomery_butterfly(input int px, input int py, input word_t w);
    logic [127:0] u, h;
    word_t qw, qq, v, x, s;
    qw = {2'b00, mod_q};
    u = coef_mem[py] * w;
    qq = u[63:0] * mod_qinv;
    h = qq * qw;
    v = (u[127:64] < h[127:64]) ? u[127:64] + qw - h[127:64] : u[127:64] - h[127:64];
    x = coef_mem[px];
    coef_mem[py] = (x < v) ? x + qw - v : x - v;
    s = x + v;
    coef_mem[px] = (s > qw) ? s - qw : s;
  endfunction

  function automatic void forward_transform();
    int lg, n, t, m, i, j;
    lg = (size_lg > 10) ? 10 : size_lg;
    n = 1 << lg;
    t = n;
    for (m = 1; m < n; m <<= 1) begin
      t >>= 1;
      for (i = 0; i < m; i++)
        for (j = 0; j < t; j++)
          montgomery_butterfly(2 * i * t + j, 2 * i * t + j + t, twid_mem[(m + i) % DEPTH]);
    end
  endfunction

  // Receiver: random stall pattern, or a long hold-off when requested.
  always @(negedge clk) begin
    if (!rst_n || hold_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", out_tdata, 64'd0);
      end else begin
        result_t exp_r;
        exp_r = pending_results.pop_front();
        if (out_tdata !== exp_r.data) report_mismatch("data", out_tdata, exp_r.data);
        if (out_tuser !== exp_r.done_res)
          report_mismatch("done_res", {63'd0, out_tuser}, {63'd0, exp_r.done_res});
      end
    end
  end

  task automatic send_item(input logic [1:0] func, input logic [9:0] idx,
                           input logic [63:0] value);
    result_t r;
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {6'd0, value, idx};
    do @(posedge clk); while (!in_tready);
    case (func)
      FUNC_WR_COEF: begin coef_mem[idx] = value; coef_written[idx] = 1'b1; end
      FUNC_WR_TWID: twid_mem[idx] = value;
      FUNC_RUN: begin
        forward_transform();
        r.data = '0; r.done_res = 1'b1; pending_results.push_back(r);
      end
      default: begin
        r.data = coef_mem[idx]; r.done_res = 1'b0; pending_results.push_back(r);
      end
    endcase
    @(negedge clk);
    if ($urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MODULUS:  mod_q = value[61:0];
      CFG_MOD_INV:  mod_qinv = value;
      CFG_SIZE_LOG: size_lg = value[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic word_t inv64(input word_t q);
    word_t x;
    x = q;
    repeat (6) x = x * (64'd2 - q * x);
    return x;
  endfunction

  task automatic set_modulus(input logic [61:0] q);
    write_reg(CFG_MODULUS, {2'b00, q});
    write_reg(CFG_MOD_INV, inv64({2'b00, q}));
  endtask

  task automatic fill_and_run(input int n, input bit reduced);
    int k;
    for (k = 0; k < n; k++)
      send_item(FUNC_WR_COEF, k[9:0], reduced ? {$urandom, $urandom} % {2'b00, mod_q}
                                             : {$urandom, $urandom});
    for (k = 1; k < n; k++) send_item(FUNC_WR_TWID, k[9:0], {$urandom, $urandom});
    send_item(FUNC_RUN, 10'd0, {$urandom, $urandom});
    for (k = 0; k < n; k++) send_item(FUNC_RD_COEF, k[9:0], {$urandom, $urandom});
  endtask

  task automatic test_directed();
    set_modulus(62'd3);
    write_reg(CFG_SIZE_LOG, 64'd0);
    send_item(FUNC_WR_COEF, 10'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(FUNC_WR_COEF, 10'h3FF, 64'd0);
    send_item(FUNC_RD_COEF, 10'h3FF, 64'd0);
    send_item(FUNC_RUN, 10'd0, 64'd0);
    send_item(FUNC_RD_COEF, 10'd0, 64'd0);
    write_reg(CFG_SIZE_LOG, 64'd1);
    send_item(FUNC_WR_COEF, 10'd1, 64'h5555_5555_5555_5555);
    send_item(FUNC_WR_TWID, 10'd1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(FUNC_RUN, 10'h3FF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(FUNC_RD_COEF, 10'd0, 64'd0);
    send_item(FUNC_RD_COEF, 10'd1, 64'd0);
    set_modulus(62'h3FFF_FFFF_FFFF_FFFF);
    write_reg(CFG_SIZE_LOG, 64'd2);
    fill_and_run(4, 1'b0);
  endtask

  task automatic test_random_transforms();
    int r, lg;
    for (r = 0; r < 3; r++) begin
      set_modulus(62'({$urandom, $urandom}) | 62'd1);
      lg = $urandom_range(1, 3);
      write_reg(CFG_SIZE_LOG, 64'(lg));
      fill_and_run(1 << lg, r[0]);
    end
  endtask

  task automatic test_random_access();
    int k;
    logic [9:0] idx;
    for (k = 0; k < 24; k++) begin
      idx = 10'($urandom);
      if ($urandom_range(0, 1) == 0 || !coef_written[idx])
        send_item($urandom_range(0, 1) ? FUNC_WR_COEF : FUNC_WR_TWID, idx, {$urandom, $urandom});
      else send_item(FUNC_RD_COEF, idx, {$urandom, $urandom});
    end
  endtask

  task automatic test_backpressure();
    int k;
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      for (k = 0; k < 12; k++) send_item(FUNC_RD_COEF, k[9:0] % 4, 64'd0);
    join
    drain();
  endtask

  task automatic test_ignored_config();
    write_reg(CFG_SIZE_LOG, 64'd1);
    write_reg(CFG_UNMAPPED, 64'd5);
    fill_and_run(2, 1'b1);
  endtask

  initial begin
    mod_q = 62'd3;
    mod_qinv = 64'hAAAA_AAAA_AAAA_AAAB;
    size_lg = 4'd10;
    foreach (coef_written[k]) coef_written[k] = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random_transforms();
    test_random_access();
    test_backpressure();
    test_ignored_config();
    drain();
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
